[rtl/typed_byte_packet_deframer_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the typed byte packet deframer
// Clocked concurrent assertions, removed for synthesis.
// ---------------------------------------------------------------------------
`ifndef TYPED_BYTE_PACKET_DEFRAMER_ASSERT_SVH
`define TYPED_BYTE_PACKET_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define TBPD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("tbpd assertion failed");
// checked at every edge, reset included
`define TBPD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
	else $error("tbpd assertion failed");
`else
`define TBPD_ASSERT(lbl, prop)
`define TBPD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/tbpd_pkg.sv]
// ---------------------------------------------------------------------------
// tbpd_pkg
// Shared codes, widths and transfer types of the byte packet deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbpd_pkg;

	// header codes seen while idle
	localparam logic [7:0] HDR_WHEEL = 8'hA1;
	localparam logic [7:0] HDR_IMAGE = 8'hB1;
	localparam logic [7:0] HDR_DONE  = 8'hE1;

	// result kinds
	localparam logic [1:0] RES_WHEEL = 2'd0;
	localparam logic [1:0] RES_IMAGE = 2'd1;
	localparam logic [1:0] RES_DONE  = 2'd2;

	// frame lengths, as last payload positions
	localparam logic [2:0] WHEEL_LAST_POS = 3'd1;
	localparam logic [2:0] IMAGE_LAST_POS = 3'd7;

	// command queue geometry
	localparam int QAW    = 2;
	localparam int QCW    = QAW + 1;
	localparam int QDEPTH = 1 << QAW;

	typedef enum logic [1:0] {
		OP_DONE  = 2'd0,
		OP_WHEEL = 2'd1,
		OP_IMAGE = 2'd2
	} op_code_t;

	// one command from the front to the back
	typedef struct packed {
		op_code_t   code;
		logic [2:0] pos;
		logic       last;
		logic [7:0] data;
	} op_t;

	// a command offered on one side of the queue
	typedef struct packed {
		logic valid;
		op_t  op;
	} op_xfer_t;

endpackage

[rtl/tbpd_front.sv]
// ---------------------------------------------------------------------------
// tbpd_front
// Accepts bytes, tracks framing and turns each payload byte and done header into a command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbpd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	input  logic [7:0]          rx_byte,
	input  logic                q_full,
	output tbpd_pkg::op_xfer_t  push
);

	typedef enum logic [2:0] {
		FR_IDLE  = 3'b001,
		FR_WHEEL = 3'b010,
		FR_IMAGE = 3'b100
	} frame_t;

	frame_t     frame_q, frame_d;
	logic [2:0] pos_q, pos_d;
	logic       accept;

	assign accept = rx_valid && !q_full;

	always_comb begin
		frame_d       = frame_q;
		pos_d         = pos_q;
		push.valid    = 1'b0;
		push.op.code  = tbpd_pkg::OP_DONE;
		push.op.pos   = pos_q;
		push.op.last  = 1'b0;
		push.op.data  = rx_byte;
		if (accept) begin
			unique case (frame_q)
				FR_WHEEL: begin
					push.valid    = 1'b1;
					push.op.code  = tbpd_pkg::OP_WHEEL;
					push.op.last  = (pos_q == tbpd_pkg::WHEEL_LAST_POS);
					if (pos_q == tbpd_pkg::WHEEL_LAST_POS) begin
						frame_d = FR_IDLE;
						pos_d   = 3'd0;
					end else begin
						pos_d = pos_q + 3'd1;
					end
				end
				FR_IMAGE: begin
					push.valid    = 1'b1;
					push.op.code  = tbpd_pkg::OP_IMAGE;
					push.op.last  = (pos_q == tbpd_pkg::IMAGE_LAST_POS);
					// position wraps to zero after the eighth byte
					pos_d = pos_q + 3'd1;
					if (pos_q == tbpd_pkg::IMAGE_LAST_POS) begin
						frame_d = FR_IDLE;
					end
				end
				default: begin
					pos_d = 3'd0;
					priority if (rx_byte == tbpd_pkg::HDR_WHEEL) begin
						frame_d = FR_WHEEL;
					end else if (rx_byte == tbpd_pkg::HDR_IMAGE) begin
						frame_d = FR_IMAGE;
					end else if (rx_byte == tbpd_pkg::HDR_DONE) begin
						push.valid   = 1'b1;
						push.op.code = tbpd_pkg::OP_DONE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= FR_IDLE;
			pos_q   <= 3'd0;
		end else begin
			frame_q <= frame_d;
			pos_q   <= pos_d;
		end
	end

endmodule

[rtl/tbpd_queue.sv]
// ---------------------------------------------------------------------------
// tbpd_queue
// Short command FIFO between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbpd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  tbpd_pkg::op_xfer_t  push,
	input  logic                pop,
	output tbpd_pkg::op_xfer_t  head,
	output logic                full
);

	tbpd_pkg::op_t                 mem_q [tbpd_pkg::QDEPTH];
	logic [tbpd_pkg::QAW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [tbpd_pkg::QCW-1:0]      cnt_q;
	logic                          do_push, do_pop;

	assign full       = (cnt_q == tbpd_pkg::QCW'(tbpd_pkg::QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.op    = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + tbpd_pkg::QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + tbpd_pkg::QAW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + tbpd_pkg::QCW'(1);
				2'b01:   cnt_q <= cnt_q - tbpd_pkg::QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/tbpd_back.sv]
// ---------------------------------------------------------------------------
// tbpd_back
// Executes commands: payload store, toggle, word count, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbpd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tbpd_pkg::op_xfer_t  head,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [1:0]          result_kind,
	output logic [15:0]         wheel_value,
	output logic [63:0]         image_word,
	output logic                valid_toggle,
	output logic [31:0]         words_received
);

	logic [7:0]  payload_q [8];
	logic        toggle_q;
	logic [31:0] count_q;
	logic        valid_q;
	logic        can_load;
	logic        emit;
	logic        is_image_end;
	logic        toggle_d;
	logic [31:0] count_d;
	logic [1:0]  kind_d;
	logic [15:0] wheel_d;
	logic [63:0] word_d;

	assign can_load     = !valid_q || !res_stall;
	assign pop          = head.valid && can_load;
	assign is_image_end = (head.op.code == tbpd_pkg::OP_IMAGE) && head.op.last;
	assign toggle_d     = is_image_end ? !toggle_q : toggle_q;
	assign count_d      = is_image_end ? count_q + 32'd1 : count_q;

	always_comb begin
		emit    = 1'b0;
		kind_d  = tbpd_pkg::RES_DONE;
		wheel_d = '0;
		word_d  = '0;
		unique case (head.op.code)
			tbpd_pkg::OP_WHEEL: begin
				emit    = head.op.last;
				kind_d  = tbpd_pkg::RES_WHEEL;
				wheel_d = {head.op.data, payload_q[0]};
			end
			tbpd_pkg::OP_IMAGE: begin
				emit   = head.op.last;
				kind_d = tbpd_pkg::RES_IMAGE;
				word_d = {head.op.data, payload_q[6], payload_q[5], payload_q[4],
				          payload_q[3], payload_q[2], payload_q[1], payload_q[0]};
			end
			default: begin
				emit = 1'b1;
			end
		endcase
	end

	// payload store: never read before the same frame wrote it
	always_ff @(posedge clk) begin
		if (pop && (head.op.code != tbpd_pkg::OP_DONE)) begin
			payload_q[head.op.pos] <= head.op.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q <= 1'b0;
			count_q  <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				toggle_q <= toggle_d;
				count_q  <= count_d;
			end
			if (can_load) begin
				valid_q <= pop && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit && can_load) begin
			result_kind    <= kind_d;
			wheel_value    <= wheel_d;
			image_word     <= word_d;
			valid_toggle   <= toggle_d;
			words_received <= count_d;
		end
	end

	assign res_valid = valid_q;

endmodule

[rtl/typed_byte_packet_deframer.sv]
// ---------------------------------------------------------------------------
// typed_byte_packet_deframer
// Splits a serial byte stream into wheel, image-word and image-done results.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  rx      | rx_valid, rx_stall | rx_byte
//  res     | res_valid,res_stall| result_kind, wheel_value, image_word,
//          |                    | valid_toggle, words_received
//
//  One byte per cycle while the command queue is not full: the front
//  classifies a byte combinationally and the back retires one queued
//  command per cycle unless a stalled result holds it. The last byte of a
//  frame reaches its result via the queue write, then the result register.
//  arst_n clears framing, queue pointers, toggle, counter and result valid;
//  the payload store needs no clearing.
//  rx_stall rises only when the four-entry command queue is full; a stalled
//  result holds while the queue keeps taking bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "typed_byte_packet_deframer_assert.svh"

module typed_byte_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  result_kind,
	output logic [15:0] wheel_value,
	output logic [63:0] image_word,
	output logic        valid_toggle,
	output logic [31:0] words_received
);

	// front -> queue command, queue head -> back
	tbpd_pkg::op_xfer_t push;
	tbpd_pkg::op_xfer_t head;
	logic               q_full;
	logic               pop;

	// front end: header detection and frame position
	tbpd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte),
		.q_full (q_full),
		.push   (push)
	);

	// decoupling queue; a full queue is the only source of input stall
	tbpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (q_full)
	);

	assign rx_stall = q_full;

	// back end: payload assembly, toggle/counter, result register
	tbpd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.result_kind    (result_kind),
		.wheel_value    (wheel_value),
		.image_word     (image_word),
		.valid_toggle   (valid_toggle),
		.words_received (words_received)
	);

	// a full queue never sees a command pushed at it
	`TBPD_ASSERT(a_no_push_when_full, q_full |-> !push.valid)
	// no result is offered in the cycle after an edge taken in reset
	`TBPD_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |=> !res_valid)
	// fields unused by the result kind read as zero
	`TBPD_ASSERT(a_unused_zero, res_valid |->
		((result_kind == tbpd_pkg::RES_WHEEL && image_word == 64'd0) ||
		 (result_kind == tbpd_pkg::RES_IMAGE && wheel_value == 16'd0) ||
		 (result_kind == tbpd_pkg::RES_DONE && image_word == 64'd0 &&
		  wheel_value == 16'd0)))
	// the back end only pops a valid queue head
	`TBPD_ASSERT(a_pop_only_valid, pop |-> head.valid)

endmodule
